>>> sv/sfp_pkg.sv
// Shared constants and result type of the sniffer serial frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

   // Framing bytes and info codes
   localparam logic [7:0] SOF0      = 8'h40;
   localparam logic [7:0] SOF1      = 8'h53;
   localparam logic [7:0] EOF1      = 8'h45;
   localparam logic [7:0] INFO_CMD  = 8'h80;
   localparam logic [7:0] INFO_DATA = 8'hC0;
   localparam logic [7:0] INFO_ERR  = 8'hC1;
   localparam logic [1:0] DIR_BAD   = 2'h3;

   // Fixed body bytes of a data frame around its payload
   localparam logic [15:0] DATA_OVERHEAD = 16'd12;

   // Data frame body positions
   localparam int unsigned POS_TS_END  = 6;
   localparam int unsigned POS_CHANNEL = 6;
   localparam int unsigned POS_DIR     = 9;
   localparam int unsigned POS_PAYLOAD = 10;

   // Result kinds
   localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
   localparam logic [2:0] KIND_DATA_END = 3'd1;
   localparam logic [2:0] KIND_CMD_END  = 3'd2;
   localparam logic [2:0] KIND_ERR_END  = 3'd3;
   localparam logic [2:0] KIND_REJECT   = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  payload_byte;
      logic [11:0] payload_length;
      logic [47:0] stamp_us;
      logic [7:0]  channel;
      logic [1:0]  direction;
      logic [7:0]  rssi_magnitude;
      logic        crc_ok;
      logic        checksum_ok;
      logic        last;
   } result_type;

endpackage

>>> sv/sniffer_serial_frame_parser_top.sv
// Top level of the sniffer serial frame parser: byte parser, result register and skid stage.
`timescale 1ns / 1ps

// The parser takes one serial byte per beat on the req_ channel and can accept a beat in
// every clock cycle while req_tready is high, so it sustains one byte per cycle. Each byte
// updates the frame state (phase, body position, length, info byte, running checksum and the
// held data frame fields) in a single registered step; any result it causes is registered
// into the result register, or the skid stage while that is held. A result register followed
// by a one-entry skid stage parts the two sides: bytes keep flowing while a result waits,
// and req_tready falls only when both stages hold a result, as when a result arrives behind
// a stalled one. Payload bytes of data frames stream out as kind 0 beats with tlast low;
// every frame end and every reject is a single beat with tlast high. Data frames are parsed
// but give no payload or data end beats while capture is disabled. The user must write the
// capture bit through csr_wr_en and csr_wr_data only while the block is idle; the block does
// not enforce it. Reset clears the bit. No storage needs clearing after reset.
module sniffer_serial_frame_parser_top
   import sfp_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,    // capture_enabled
   // Byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,      // rx_byte
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,      // payload_byte, payload_length, stamp_us, channel,
                                       // direction, rssi_magnitude, crc_ok, checksum_ok
   output logic [2:0]  rsp_tuser,      // kind
   output logic        rsp_tlast       // last
);

   // Body positions never reach MAX_FRAME_BYTES, so this many bits cover them.
   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES);
   localparam logic [16:0] LIMIT_OTHER = 17'(MAX_FRAME_BYTES - 7);
   localparam logic [16:0] LIMIT_CMD   = 17'(MAX_FRAME_BYTES - 8);

   typedef enum logic [3:0] {
      PH_HUNT0, PH_HUNT1, PH_INFO, PH_LENLO, PH_LENHI, PH_BODY, PH_FCS, PH_END0, PH_END1
   } phase_type;

   // Parser state
   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       info_ff, info_in;
   logic [7:0]       sum_ff, sum_in;
   logic [47:0]      ts_ff, ts_in;
   logic [7:0]       chan_ff, chan_in;
   logic [1:0]       dir_ff, dir_in;
   logic [7:0]       rssi_ff, rssi_in;
   logic             crc_ff, crc_in;
   logic             capture_ff;

   // Result stages
   logic       out_vld_ff, skid_vld_ff;
   result_type out_ff, skid_ff;
   logic       res_vld;
   result_type res;

   logic             accept;
   logic             take;
   logic [POS_W-1:0] pos_next;
   logic [15:0]      pos_wide;
   logic [15:0]      len_new;
   logic             data_full;
   logic             body_done;

   assign accept   = req_tvalid && req_tready;
   assign take     = out_vld_ff && rsp_tready;
   assign pos_next = pos_ff + POS_W'(1);
   assign pos_wide = 16'(pos_ff);
   assign len_new  = {req_tdata, len_ff[7:0]};
   assign data_full = (info_ff == INFO_DATA) && (len_ff >= DATA_OVERHEAD);
   assign body_done = 16'(pos_next) >= len_ff;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      info_in  = info_ff;
      sum_in   = sum_ff;
      ts_in    = ts_ff;
      chan_in  = chan_ff;
      dir_in   = dir_ff;
      rssi_in  = rssi_ff;
      crc_in   = crc_ff;
      res_vld  = 1'b0;
      res      = '0;
      res.last = 1'b1;

      case (phase_ff)
         PH_HUNT0: begin
            if (req_tdata == SOF0) begin
               phase_in = PH_HUNT1;
            end
         end
         PH_HUNT1: begin
            if (req_tdata == SOF1) begin
               // A new frame starts: forget everything held from the last one.
               phase_in = PH_INFO;
               pos_in   = '0;
               len_in   = '0;
               info_in  = '0;
               sum_in   = '0;
               ts_in    = '0;
               chan_in  = '0;
               dir_in   = '0;
               rssi_in  = '0;
               crc_in   = 1'b0;
            end else if (req_tdata != SOF0) begin
               phase_in = PH_HUNT0;
            end
         end
         PH_INFO: begin
            info_in  = req_tdata;
            sum_in   = req_tdata;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            len_in   = {8'h00, req_tdata};
            sum_in   = sum_ff + req_tdata;
            phase_in = PH_LENHI;
         end
         PH_LENHI: begin
            len_in = len_new;
            sum_in = sum_ff + req_tdata;
            pos_in = '0;
            if ({1'b0, len_new} > ((info_ff == INFO_CMD) ? LIMIT_CMD : LIMIT_OTHER)) begin
               phase_in = PH_HUNT0;
               res_vld  = 1'b1;
               res.kind = KIND_REJECT;
            end else if (len_new == 16'd0) begin
               phase_in = (info_ff == INFO_CMD) ? PH_FCS : PH_END0;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            sum_in = sum_ff + req_tdata;
            if (data_full) begin
               if (pos_wide < 16'(POS_TS_END)) begin
                  ts_in[{pos_ff[2:0], 3'b000} +: 8] = req_tdata;
               end else if (pos_wide == 16'(POS_CHANNEL)) begin
                  chan_in = req_tdata;
               end else if (pos_wide == 16'(POS_DIR)) begin
                  dir_in = (req_tdata[1:0] == DIR_BAD) ? 2'd0 : req_tdata[1:0];
               end else if (pos_wide == len_ff - 16'd2) begin
                  rssi_in = req_tdata;
               end else if (pos_wide == len_ff - 16'd1) begin
                  crc_in = req_tdata[7];
               end else if (pos_wide >= 16'(POS_PAYLOAD) && capture_ff) begin
                  res_vld          = 1'b1;
                  res.kind         = KIND_PAYLOAD;
                  res.payload_byte = req_tdata;
                  res.last         = 1'b0;
               end
            end
            pos_in = pos_next;
            if (body_done) begin
               phase_in = (info_ff == INFO_CMD) ? PH_FCS : PH_END0;
            end
         end
         PH_FCS: begin
            crc_in   = (sum_ff == req_tdata);
            phase_in = PH_END0;
         end
         PH_END0: begin
            if (req_tdata != SOF0) begin
               phase_in = PH_HUNT0;
               res_vld  = 1'b1;
               res.kind = KIND_REJECT;
            end else begin
               phase_in = PH_END1;
            end
         end
         PH_END1: begin
            phase_in = PH_HUNT0;
            if (req_tdata != EOF1) begin
               res_vld  = 1'b1;
               res.kind = KIND_REJECT;
            end else if (info_ff == INFO_CMD) begin
               res_vld            = 1'b1;
               res.kind           = KIND_CMD_END;
               res.payload_length = len_ff[11:0];
               res.checksum_ok    = crc_ff;
            end else if (info_ff == INFO_ERR) begin
               res_vld            = 1'b1;
               res.kind           = KIND_ERR_END;
               res.payload_length = len_ff[11:0];
            end else if (info_ff != INFO_DATA) begin
               res_vld  = 1'b1;
               res.kind = KIND_REJECT;
            end else if (capture_ff) begin
               res_vld = 1'b1;
               if (len_ff < DATA_OVERHEAD) begin
                  res.kind = KIND_REJECT;
               end else begin
                  res.kind           = KIND_DATA_END;
                  res.payload_length = 12'(len_ff - DATA_OVERHEAD);
                  res.stamp_us       = ts_ff;
                  res.channel        = chan_ff;
                  res.direction      = dir_ff;
                  res.rssi_magnitude = rssi_ff;
                  res.crc_ok         = crc_ff;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT0;
         end
      endcase
   end

   // Parser state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT0;
         capture_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capture_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         info_ff <= info_in;
         sum_ff  <= sum_in;
         ts_ff   <= ts_in;
         chan_ff <= chan_in;
         dir_ff  <= dir_in;
         rssi_ff <= rssi_in;
         crc_ff  <= crc_in;
      end
   end

   // Result register and skid stage. The skid entry only fills while the result
   // register is held by a stalled consumer, and empties first when it drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!out_vld_ff || take) begin
            if (skid_vld_ff) begin
               out_vld_ff  <= 1'b1;
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= accept && res_vld;
            end
         end else if (accept && res_vld) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || take) begin
         out_ff <= skid_vld_ff ? skid_ff : res;
      end else if (accept && res_vld) begin
         skid_ff <= res;
      end
   end

   assign req_tready = !skid_vld_ff;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {out_ff.checksum_ok, out_ff.crc_ok, out_ff.rssi_magnitude,
                        out_ff.direction, out_ff.channel, out_ff.stamp_us,
                        out_ff.payload_length, out_ff.payload_byte};

`ifndef SYNTHESIS
   // The skid entry is only ever occupied behind a full result register.
   assert property (@(posedge clock) disable iff (reset) skid_vld_ff |-> out_vld_ff)
      else $error("skid stage holds a result while the result register is empty");

   // Within a frame body the position never passes the length.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (pos_wide < len_ff))
      else $error("body position ran past the frame length");

   // Any byte taken at the second end byte returns the parser to hunting.
   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_END1) |=> (phase_ff == PH_HUNT0))
      else $error("parser did not resume hunting after the end of a frame");

   // A payload beat never closes a run; every other kind does.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_PAYLOAD)))
      else $error("tlast does not match the result kind");
`endif

endmodule
